// ===== src/afsc_pkg.sv =====
// Shared types and constants for the frustum side-plane box cull.
// No dependencies; imported by every module of the block.
package afsc_pkg;

    // Configuration register file
    localparam int PLANE_REGS  = 4;
    localparam int PLANE_IDX_W = 2;
    localparam int PLANE_W     = 64;
    localparam int ADDR_W      = 5;
    localparam int ADDR_LSB    = 3;

    // Field widths
    localparam int COORD_W = 24;
    localparam int SIZE_W  = 25;
    localparam int NRM_W   = 12;
    localparam int D_W     = 28;
    localparam int PM_W    = NRM_W + COORD_W;
    localparam int PS_W    = NRM_W + SIZE_W;
    localparam int SUM_W   = 41;
    localparam int D_SHIFT = 10;

    // Plane register packing
    localparam int NX_LSB = 0;
    localparam int NY_LSB = 12;
    localparam int NZ_LSB = 24;
    localparam int D_LSB  = 36;

    // Verdict codes
    typedef enum logic [1:0] {
        CULL_OUTSIDE    = 2'd0,
        CULL_INTERSECTS = 2'd1,
        CULL_CONTAINS   = 2'd2
    } cull_t;

    // One box travelling down the cell chain with its verdict so far
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [SIZE_W-1:0]  size_x;
        logic signed [SIZE_W-1:0]  size_y;
        logic signed [SIZE_W-1:0]  size_z;
        cull_t                     code;
    } item_t;

endpackage

// ===== src/afsc_regs.sv =====
// APB-style register file holding the packed side planes.
// Depends on afsc_pkg.
module afsc_regs (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               psel,
    input  logic                                               penable,
    input  logic                                               pwrite,
    input  logic [afsc_pkg::ADDR_W-1:0]                        paddr,
    input  logic [afsc_pkg::PLANE_W-1:0]                       pwdata,
    output logic [afsc_pkg::PLANE_W-1:0]                       prdata,
    output logic                                               pready,
    output logic [afsc_pkg::PLANE_REGS-1:0][afsc_pkg::PLANE_W-1:0] planes
);
    import afsc_pkg::*;

    logic [PLANE_REGS-1:0][PLANE_W-1:0] plane_reg;
    logic [PLANE_REGS-1:0][PLANE_W-1:0] plane_next;
    logic [PLANE_IDX_W-1:0]             idx;
    logic                               wr_en;

    assign idx    = paddr[ADDR_LSB +: PLANE_IDX_W];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = plane_reg[idx];
    assign planes = plane_reg;

    // write decode
    always_comb
    begin
        plane_next = plane_reg;
        if (wr_en)
        begin
            plane_next[idx] = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else
        begin
            plane_reg <= plane_next;
        end
    end

endmodule

// ===== src/afsc_cell.sv =====
// One cell of the cull chain: tests a box against one side plane over
// three pipeline stages and updates the running verdict. Depends on afsc_pkg.
module afsc_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [afsc_pkg::PLANE_W-1:0] plane,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  afsc_pkg::item_t              in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output afsc_pkg::item_t              out_item
);
    import afsc_pkg::*;

    // plane fields
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic signed [D_W-1:0]   d;

    assign nx = $signed(plane[NX_LSB +: NRM_W]);
    assign ny = $signed(plane[NY_LSB +: NRM_W]);
    assign nz = $signed(plane[NZ_LSB +: NRM_W]);
    assign d  = $signed(plane[D_LSB +: D_W]);

    // stage handshake
    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // stage 1: normal times min corner and normal times size
    item_t                   item1_reg;
    logic signed [PM_W-1:0]  pm_x_reg, pm_y_reg, pm_z_reg;
    logic signed [PM_W-1:0]  pm_x_next, pm_y_next, pm_z_next;
    logic signed [PS_W-1:0]  ps_x_reg, ps_y_reg, ps_z_reg;
    logic signed [PS_W-1:0]  ps_x_next, ps_y_next, ps_z_next;

    always_comb
    begin
        pm_x_next = PM_W'(nx) * PM_W'(in_item.min_x);
        pm_y_next = PM_W'(ny) * PM_W'(in_item.min_y);
        pm_z_next = PM_W'(nz) * PM_W'(in_item.min_z);
        ps_x_next = PS_W'(nx) * PS_W'(in_item.size_x);
        ps_y_next = PS_W'(ny) * PS_W'(in_item.size_y);
        ps_z_next = PS_W'(nz) * PS_W'(in_item.size_z);
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            item1_reg <= in_item;
            pm_x_reg  <= pm_x_next;
            pm_y_reg  <= pm_y_next;
            pm_z_reg  <= pm_z_next;
            ps_x_reg  <= ps_x_next;
            ps_y_reg  <= ps_y_next;
            ps_z_reg  <= ps_z_next;
        end
    end

    // stage 2: distance of the min corner, positive and negative extents
    item_t                   item2_reg;
    logic signed [SUM_W-1:0] base_reg, pos_reg, neg_reg;
    logic signed [SUM_W-1:0] base_next, pos_next, neg_next;
    logic signed [SUM_W-1:0] sx, sy, sz;

    always_comb
    begin
        sx        = SUM_W'(ps_x_reg);
        sy        = SUM_W'(ps_y_reg);
        sz        = SUM_W'(ps_z_reg);
        base_next = (SUM_W'(d) <<< D_SHIFT) + SUM_W'(pm_x_reg)
                    + SUM_W'(pm_y_reg) + SUM_W'(pm_z_reg);
        pos_next  = (sx[SUM_W-1] ? '0 : sx) + (sy[SUM_W-1] ? '0 : sy)
                    + (sz[SUM_W-1] ? '0 : sz);
        neg_next  = (sx[SUM_W-1] ? sx : '0) + (sy[SUM_W-1] ? sy : '0)
                    + (sz[SUM_W-1] ? sz : '0);
    end

    always_ff @(posedge clk)
    begin
        if (r2 && v1_reg)
        begin
            item2_reg <= item1_reg;
            base_reg  <= base_next;
            pos_reg   <= pos_next;
            neg_reg   <= neg_next;
        end
    end

    // stage 3: bounds, compare, merge verdict (outside is sticky)
    item_t                   item3_reg;
    item_t                   item3_next;
    logic signed [SUM_W-1:0] lower, upper;
    logic                    lower_pos, upper_pos;

    always_comb
    begin
        lower      = base_reg + neg_reg;
        upper      = base_reg + pos_reg;
        lower_pos  = !lower[SUM_W-1] && (lower != '0);
        upper_pos  = !upper[SUM_W-1] && (upper != '0);
        item3_next = item2_reg;
        if (item2_reg.code != CULL_OUTSIDE)
        begin
            if (lower_pos)
            begin
                item3_next.code = CULL_OUTSIDE;
            end
            else if (upper_pos)
            begin
                item3_next.code = CULL_INTERSECTS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            item3_reg <= item3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

// ===== src/aabb_frustum_side_cull.sv =====
// Top level of the frustum side-plane box cull: register file, size stage
// and a chain of one afsc_cell per side plane. Depends on afsc_pkg,
// afsc_regs and afsc_cell.
//
// Usage:
//   Boxes arrive on the in_valid/in_ready channel as min and max corners
//   (signed Q15.8). Each request yields one cull_result on the
//   out_valid/out_ready channel: 0 outside, 1 intersects, 2 contained.
//   Side planes are written through the APB port at byte address 8*i;
//   write them only while no box is in flight.
// Pipeline: a size stage, then three stages per plane cell (multiply, sum,
//   compare) between acceptance and out_valid.
// Throughput: one box per cycle while out_ready is high; each stage holds one box
//   and moves it on whenever the stage ahead is empty or moving.
// Reset: rst_n clears all pipeline valids and every plane register to zero;
//   a zero plane never changes the verdict.
// Stall: when out_ready is low the final result is held; upstream stages
//   keep filling bubbles, and in_ready drops only once every stage is full.
module aabb_frustum_side_cull #(
    parameter int NUM_SIDE_PLANES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [afsc_pkg::ADDR_W-1:0]         paddr,
    input  logic [afsc_pkg::PLANE_W-1:0]        pwdata,
    output logic [afsc_pkg::PLANE_W-1:0]        prdata,
    output logic                                pready,
    // box requests
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [afsc_pkg::COORD_W-1:0] box_min_x,
    input  logic signed [afsc_pkg::COORD_W-1:0] box_min_y,
    input  logic signed [afsc_pkg::COORD_W-1:0] box_min_z,
    input  logic signed [afsc_pkg::COORD_W-1:0] box_max_x,
    input  logic signed [afsc_pkg::COORD_W-1:0] box_max_y,
    input  logic signed [afsc_pkg::COORD_W-1:0] box_max_z,
    // results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          cull_result
);
    import afsc_pkg::*;

    logic [PLANE_REGS-1:0][PLANE_W-1:0] planes;

    afsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // links between stages: index 0 is the size stage output
    item_t link_item  [NUM_SIDE_PLANES+1];
    logic  link_valid [NUM_SIDE_PLANES+1];
    logic  link_ready [NUM_SIDE_PLANES+1];

    // size stage: min corner and max - min
    logic  front_v_reg;
    item_t front_item_reg;
    item_t front_item_next;

    always_comb
    begin
        front_item_next.min_x  = box_min_x;
        front_item_next.min_y  = box_min_y;
        front_item_next.min_z  = box_min_z;
        front_item_next.size_x = SIZE_W'(box_max_x) - SIZE_W'(box_min_x);
        front_item_next.size_y = SIZE_W'(box_max_y) - SIZE_W'(box_min_y);
        front_item_next.size_z = SIZE_W'(box_max_z) - SIZE_W'(box_min_z);
        front_item_next.code   = CULL_CONTAINS;
    end

    assign in_ready = !front_v_reg || link_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            front_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            front_item_reg <= front_item_next;
        end
    end

    assign link_valid[0] = front_v_reg;
    assign link_item[0]  = front_item_reg;

    // one cell per side plane; planes past the register file read as zero
    for (genvar g = 0; g < NUM_SIDE_PLANES; g++)
    begin : g_cell
        logic [PLANE_W-1:0] plane_sel;

        if (g < PLANE_REGS)
        begin : g_reg
            assign plane_sel = planes[g];
        end
        else
        begin : g_zero
            assign plane_sel = '0;
        end

        afsc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .plane     (plane_sel),
            .in_valid  (link_valid[g]),
            .in_ready  (link_ready[g]),
            .in_item   (link_item[g]),
            .out_valid (link_valid[g+1]),
            .out_ready (link_ready[g+1]),
            .out_item  (link_item[g+1])
        );
    end

    assign link_ready[NUM_SIDE_PLANES] = out_ready;
    assign out_valid   = link_valid[NUM_SIDE_PLANES];
    assign cull_result = link_item[NUM_SIDE_PLANES].code;

    // checks
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    a_front_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> link_valid[0])
        else $error("accepted box not held in size stage");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

endmodule
